>>> design/assd_pkg.sv
// Shared types and constants of the audio sound/silence detector.
`default_nettype none
package assd_pkg;

  // Longest capture period in frames; a frame that reaches it closes the period.
  localparam int PERIOD_FRAMES = 1024;
  localparam int FRAME_W       = $clog2(PERIOD_FRAMES + 1);

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int SUM_W    = 42;
  localparam int THR_W    = 15;
  localparam int LEVEL_W  = THR_W + 1;
  localparam int CNT_W    = 8;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [THR_W-1:0] THRESHOLD_RST     = THR_W'(100);
  localparam logic [CNT_W-1:0] EVAL_INTERVAL_RST = CNT_W'(11);
  localparam logic [CNT_W-1:0] START_RUNS_RST    = CNT_W'(2);
  localparam logic [CNT_W-1:0] STOP_RUNS_RST     = CNT_W'(56);
  localparam logic [CNT_W-1:0] CNT_MAX           = {CNT_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_RUNS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_RUNS     = 2'd3;

  // Event codes of a result.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_SOUND   = 2'd1;
  localparam logic [1:0] EV_SILENCE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQL,
    ST_SQR,
    ST_ACC,
    ST_LVL,
    ST_NEED,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SQL,
    CMD_SQR,
    CMD_ACC,
    CMD_LVL,
    CMD_NEED,
    CMD_FIN
  } cmd_t;

  typedef struct packed {
    logic period_done;
    logic judge_due;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

>>> design/assd_in_if.sv
// Input channel of the detector: one stereo frame per transfer.
`default_nettype none
interface assd_in_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic        period_end;

  modport source (output valid, output left_sample, output right_sample,
                  output period_end, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input period_end, output ready);
endinterface
`default_nettype wire

>>> design/assd_out_if.sv
// Result channel of the detector: one judgement record per capture period.
`default_nettype none
interface assd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       silent;
  logic       gate_open;
  logic       loud;
  logic       judged;

  modport source (output valid, output event_res, output silent, output gate_open,
                  output loud, output judged, input ready);
  modport sink (input valid, input event_res, input silent, input gate_open,
                input loud, input judged, output ready);
endinterface
`default_nettype wire

>>> design/assd_dp.sv
// Datapath of the detector: squares, energy sum, threshold test and run counters.
`default_nettype none
module assd_dp
  import assd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [SAMPLE_W-1:0]  left_sample,
  input  wire logic [SAMPLE_W-1:0]  right_sample,
  input  wire logic                 period_end,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                event_res,
  output logic                      silent,
  output logic                      gate_open,
  output logic                      loud,
  output logic                      judged
);

  logic [THR_W-1:0]    threshold_r;
  logic [CNT_W-1:0]    eval_interval_r, start_runs_r, stop_runs_r;
  logic [SAMPLE_W-1:0] abs_l_r, abs_r_r;
  logic                period_end_r;
  logic [SQ_W-1:0]     prod_r, prod_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt, need_r;
  logic [FRAME_W-1:0]  frame_count_r, frame_count_nxt, frames;
  logic [CNT_W-1:0]    period_count_r, period_count_nxt;
  logic [CNT_W-1:0]    loud_run_r, loud_run_nxt, quiet_run_r, quiet_run_nxt;
  logic                silent_r, silent_nxt;
  logic                out_valid_r;
  logic [1:0]          event_r, event_nxt;
  logic                loud_r, judged_r;

  logic [SAMPLE_W:0]   left_x, right_x;
  logic [SAMPLE_W-1:0] abs_l, abs_r, mul_a;
  logic [LEVEL_W-1:0]  level;
  logic [CNT_W-1:0]    srun, qrun;
  logic                judge_due, loud_c;

  // Magnitudes fit in 16 unsigned bits, including that of the most negative sample.
  assign left_x  = {left_sample[SAMPLE_W-1], left_sample};
  assign right_x = {right_sample[SAMPLE_W-1], right_sample};
  assign abs_l   = left_sample[SAMPLE_W-1]  ? SAMPLE_W'(~left_x + 1'b1)  : left_sample;
  assign abs_r   = right_sample[SAMPLE_W-1] ? SAMPLE_W'(~right_x + 1'b1) : right_sample;

  assign level     = {1'b0, threshold_r} + LEVEL_W'(1);
  assign frames    = frame_count_r + FRAME_W'(1);
  assign judge_due = (period_count_r >= eval_interval_r);
  assign loud_c    = judge_due && (sum_r >= need_r);
  assign srun      = (start_runs_r == '0) ? CNT_W'(1) : start_runs_r;
  assign qrun      = (stop_runs_r == '0)  ? CNT_W'(1) : stop_runs_r;

  assign status.period_done = period_end_r || (frames == FRAME_W'(PERIOD_FRAMES));
  assign status.judge_due   = judge_due;
  assign status.out_busy    = out_valid_r && !out_ready;

  // One shared 16x16 multiplier serves both squares and the squared level.
  always_comb begin
    case (cmd)
      CMD_SQR: mul_a = abs_r_r;
      CMD_LVL: mul_a = level;
      default: mul_a = abs_l_r;
    endcase
    prod_nxt = {{SAMPLE_W{1'b0}}, mul_a} * {{SAMPLE_W{1'b0}}, mul_a};
  end

  always_comb begin
    sum_nxt          = sum_r;
    frame_count_nxt  = frame_count_r;
    period_count_nxt = period_count_r;
    loud_run_nxt     = loud_run_r;
    quiet_run_nxt    = quiet_run_r;
    silent_nxt       = silent_r;
    event_nxt        = EV_NONE;
    case (cmd)
      CMD_SQR: sum_nxt = sum_r + SUM_W'(prod_r);
      CMD_ACC: begin
        sum_nxt = sum_r + SUM_W'(prod_r);
        if (!status.period_done) frame_count_nxt = frames;
      end
      CMD_FIN: begin
        sum_nxt         = '0;
        frame_count_nxt = '0;
        if (judge_due) begin
          period_count_nxt = CNT_W'(1);
          if (loud_c) begin
            if (loud_run_r != CNT_MAX) loud_run_nxt = loud_run_r + CNT_W'(1);
            quiet_run_nxt = '0;
          end else begin
            if (quiet_run_r != CNT_MAX) quiet_run_nxt = quiet_run_r + CNT_W'(1);
            loud_run_nxt = '0;
          end
          if (silent_r && loud_run_nxt >= srun) begin
            silent_nxt = 1'b0;
            event_nxt  = EV_SOUND;
          end else if (!silent_r && quiet_run_nxt >= qrun) begin
            silent_nxt = 1'b1;
            event_nxt  = EV_SILENCE;
          end
        end else if (period_count_r != CNT_MAX) begin
          period_count_nxt = period_count_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= THRESHOLD_RST;
      eval_interval_r <= EVAL_INTERVAL_RST;
      start_runs_r    <= START_RUNS_RST;
      stop_runs_r     <= STOP_RUNS_RST;
      sum_r           <= '0;
      frame_count_r   <= '0;
      period_count_r  <= '0;
      loud_run_r      <= '0;
      quiet_run_r     <= '0;
      silent_r        <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD:     threshold_r     <= cfg_wdata[THR_W-1:0];
          CFG_EVAL_INTERVAL: eval_interval_r <= cfg_wdata[CNT_W-1:0];
          CFG_START_RUNS:    start_runs_r    <= cfg_wdata[CNT_W-1:0];
          CFG_STOP_RUNS:     stop_runs_r     <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      sum_r          <= sum_nxt;
      frame_count_r  <= frame_count_nxt;
      period_count_r <= period_count_nxt;
      loud_run_r     <= loud_run_nxt;
      quiet_run_r    <= quiet_run_nxt;
      silent_r       <= silent_nxt;
      if (cmd == CMD_FIN)  out_valid_r <= 1'b1;
      else if (out_ready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      abs_l_r      <= abs_l;
      abs_r_r      <= abs_r;
      period_end_r <= period_end;
    end
    if (cmd == CMD_SQL || cmd == CMD_SQR || cmd == CMD_LVL) prod_r <= prod_nxt;
    if (cmd == CMD_NEED) need_r <= SUM_W'(frames * prod_r);
    if (cmd == CMD_FIN) begin
      event_r  <= event_nxt;
      loud_r   <= loud_c;
      judged_r <= judge_due;
    end
  end

  assign out_valid = out_valid_r;
  assign event_res = event_r;
  assign silent    = silent_r;
  assign gate_open = (loud_run_r != '0);
  assign loud      = loud_r;
  assign judged    = judged_r;

endmodule
`default_nettype wire

>>> design/assd_ctrl.sv
// Controller of the detector: sequences the datapath through one frame.
`default_nettype none
module assd_ctrl
  import assd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_SQL;
        end
      end
      ST_SQL: begin
        cmd       = CMD_SQL;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd       = CMD_SQR;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd = CMD_ACC;
        if (!status.period_done)   state_nxt = ST_IDLE;
        else if (status.judge_due) state_nxt = ST_LVL;
        else                       state_nxt = ST_FIN;
      end
      ST_LVL: begin
        cmd       = CMD_LVL;
        state_nxt = ST_NEED;
      end
      ST_NEED: begin
        cmd       = CMD_NEED;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // The result register must be free before the period is closed.
        if (!status.out_busy) begin
          cmd       = CMD_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/audio_sound_silence_detector_top.sv
// Top level of the audio sound/silence detector.
`default_nettype none
// Takes one stereo frame per transfer and returns one result per capture period, on the
// period's last frame (period_end set, or the frame that reaches PERIOD_FRAMES frames).
// A frame that does not close a period steps through load, left square, right square and
// accumulate; the two squares take separate steps since both share the single 16x16
// multiplier. A closing frame adds a finish step, and when the period is judged also the
// squared level and the frames-times-level-squared product before it; a closing frame
// also waits while the previous result is still held in the output register. The next
// frame is taken while a result waits. Configuration is written with cfg_we, cfg_index
// and cfg_wdata and takes effect at once; write it only while the block is idle.
module audio_sound_silence_detector_top
  import assd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  assd_in_if.sink                   in_ch,
  assd_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .period_end   (in_ch.period_end),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .event_res    (out_ch.event_res),
    .silent       (out_ch.silent),
    .gate_open    (out_ch.gate_open),
    .loud         (out_ch.loud),
    .judged       (out_ch.judged)
  );

  assign in_ch.ready = in_ready;

`ifndef SYNTHESIS
  // A frame transfer starts a multi-cycle sequence; no second frame can follow at once.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("frame accepted twice in a row");

  a_event_judged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.event_res != EV_NONE || out_ch.loud)) |-> out_ch.judged)
    else $error("event or loud flag on an unjudged period");

  a_sound_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_res == EV_SOUND) |-> (!out_ch.silent && out_ch.gate_open))
    else $error("sound event without sound state");

  a_silence_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_res == EV_SILENCE) |-> (out_ch.silent && !out_ch.gate_open))
    else $error("silence event without silence state");
`endif

endmodule
`default_nettype wire

>>> tb/assd_checker.sv
// Checker of the sound/silence detector: predicts every period result and compares it.
module assd_checker
  import assd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  assd_in_if                   in_ch,
  assd_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [1:0] ev;
    logic       silent;
    logic       gate_open;
    logic       loud;
    logic       judged;
  } verdict_t;

  // Register copies.
  logic [THR_W-1:0] thr;
  logic [CNT_W-1:0] interval;
  logic [CNT_W-1:0] loud_needed;
  logic [CNT_W-1:0] quiet_needed;

  // Detector state.
  logic [SUM_W-1:0] energy;
  int unsigned      frames_in;
  logic [CNT_W-1:0] periods_since;
  logic [CNT_W-1:0] loud_streak;
  logic [CNT_W-1:0] quiet_streak;
  logic             is_silent;

  verdict_t verdict_q[$];
  int       fault_total = 0;
  int       depth;

  assign mismatches  = fault_total;
  assign outstanding = depth;

  task automatic note_fault(input string what, input logic [1:0] want, input logic [1:0] got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    fault_total = fault_total + 1;
  endtask

  // Adds one frame to the running period; returns 1 when the frame closes the period.
  function automatic bit absorb_frame(input logic signed [15:0] l, input logic signed [15:0] r,
                                      input logic pe, output verdict_t v);
    longint     sl;
    longint     sr;
    bit [63:0]  total;
    bit [63:0]  frames;
    bit [63:0]  lvl;
    bit [63:0]  need;
    logic [CNT_W-1:0] run_on;
    logic [CNT_W-1:0] run_off;
    sl = l;
    sr = r;
    v = '0;
    v.ev = EV_NONE;
    total = 64'(energy) + 64'(sl * sl) + 64'(sr * sr);
    energy = total[SUM_W-1:0];
    frames = 64'(frames_in) + 1;
    if (!pe && frames < PERIOD_FRAMES) begin
      frames_in = int'(frames);
      return 1'b0;
    end
    if (periods_since >= interval) begin
      v.judged = 1'b1;
      periods_since = CNT_W'(1);
      lvl = 64'(thr) + 1;
      need = frames * lvl * lvl;
      v.loud = (64'(energy) >= need);
      if (v.loud) begin
        if (loud_streak != CNT_MAX) loud_streak = loud_streak + CNT_W'(1);
        quiet_streak = '0;
      end else begin
        if (quiet_streak != CNT_MAX) quiet_streak = quiet_streak + CNT_W'(1);
        loud_streak = '0;
      end
      // A run length of zero behaves as one.
      run_on  = (loud_needed == '0) ? CNT_W'(1) : loud_needed;
      run_off = (quiet_needed == '0) ? CNT_W'(1) : quiet_needed;
      if (is_silent && loud_streak >= run_on) begin
        is_silent = 1'b0;
        v.ev = EV_SOUND;
      end else if (!is_silent && quiet_streak >= run_off) begin
        is_silent = 1'b1;
        v.ev = EV_SILENCE;
      end
    end else if (periods_since != CNT_MAX) begin
      periods_since = periods_since + CNT_W'(1);
    end
    energy = '0;
    frames_in = 0;
    v.silent = is_silent;
    v.gate_open = (loud_streak != '0);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t fresh;
    verdict_t want;
    if (!rst_n) begin
      thr = THRESHOLD_RST;
      interval = EVAL_INTERVAL_RST;
      loud_needed = START_RUNS_RST;
      quiet_needed = STOP_RUNS_RST;
      energy = '0;
      frames_in = 0;
      periods_since = '0;
      loud_streak = '0;
      quiet_streak = '0;
      is_silent = 1'b1;
      verdict_q.delete();
      depth <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          note_fault("result with nothing pending, event_res", EV_NONE, out_ch.event_res);
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.event_res !== want.ev) note_fault("event_res", want.ev, out_ch.event_res);
          if (out_ch.silent !== want.silent)
            note_fault("silent", {1'b0, want.silent}, {1'b0, out_ch.silent});
          if (out_ch.gate_open !== want.gate_open)
            note_fault("gate_open", {1'b0, want.gate_open}, {1'b0, out_ch.gate_open});
          if (out_ch.loud !== want.loud)
            note_fault("loud", {1'b0, want.loud}, {1'b0, out_ch.loud});
          if (out_ch.judged !== want.judged)
            note_fault("judged", {1'b0, want.judged}, {1'b0, out_ch.judged});
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD:     thr = cfg_wdata[THR_W-1:0];
          CFG_EVAL_INTERVAL: interval = cfg_wdata[CNT_W-1:0];
          CFG_START_RUNS:    loud_needed = cfg_wdata[CNT_W-1:0];
          CFG_STOP_RUNS:     quiet_needed = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (absorb_frame(in_ch.left_sample, in_ch.right_sample, in_ch.period_end, fresh))
          verdict_q.push_back(fresh);
      end
      depth <= verdict_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top of the sound/silence detector: stimulus, flow control and verdict.
module tb;
  import assd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_TARGET   = 1750;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int faults;
  int pending;
  int cycles = 0;
  int sent = 0;
  int cur_thr = 100;
  bit calm_src = 1'b0;
  bit calm_sink = 1'b0;

  assd_in_if  in_ch ();
  assd_out_if out_ch ();

  audio_sound_silence_detector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  assd_checker verdict_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (faults),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: a random stall before each transfer, or none in calm phases.
  initial begin : sink_side
    int stall;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = calm_sink ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r,
                            input logic pe);
    int gap;
    gap = calm_src ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_sample <= l;
    in_ch.right_sample <= r;
    in_ch.period_end <= pe;
    do @(posedge clk); while (!in_ch.ready);
    sent = sent + 1;
  endtask

  // Drains the block so that registers can be rewritten, then picks the next idling style.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    calm_src = ($urandom_range(0, 3) == 0);
    calm_sink = ($urandom_range(0, 3) == 0);
  endtask

  task automatic program_regs(input int thr, input int ei, input int sr, input int ss);
    logic [CFG_IDX_W-1:0] idx [4];
    int val [4];
    int i;
    idx = '{CFG_THRESHOLD, CFG_EVAL_INTERVAL, CFG_START_RUNS, CFG_STOP_RUNS};
    val = '{thr, ei, sr, ss};
    cur_thr = thr & 32'h7FFF;
    for (i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      // Bits above an 8-bit register's width must be dropped by the block.
      if (i != 0 && $urandom_range(0, 3) == 0)
        cfg_wdata <= CFG_W'(val[i] | ($urandom_range(1, 127) << 8));
      else
        cfg_wdata <= CFG_W'(val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample(input int amp);
    int m;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
    m = $urandom_range(0, amp);
    if ($urandom_range(0, 1)) m = -m;
    if (m > 32767) m = 32767;
    return 16'(m);
  endfunction

  // Amplitudes around the threshold so that judgements fall on both sides of it.
  function automatic int pick_amp(input int thr);
    int lvl;
    int amp;
    lvl = thr + 1;
    case ($urandom_range(0, 4))
      0: amp = lvl / 2;
      1: amp = lvl;
      2: amp = lvl + lvl / 4;
      3: amp = 2 * lvl;
      default: amp = 32768;
    endcase
    if (amp > 32768) amp = 32768;
    return amp;
  endfunction

  task automatic send_period(input int frames, input int amp, input bit mark_end);
    int f;
    for (f = 0; f < frames; f++)
      send_frame(pick_sample(amp), pick_sample(amp), mark_end && (f == frames - 1));
  endtask

  task automatic run_mixed(input int items);
    int goal;
    int frames;
    goal = sent + items;
    while (sent < goal) begin
      frames = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_period(frames, pick_amp(cur_thr), 1'b1);
    end
  endtask

  task automatic random_config();
    int thr;
    int ei;
    case ($urandom_range(0, 7))
      0: thr = 1;
      1: thr = 32767;
      2, 3: thr = $urandom_range(1, 20);
      4, 5: thr = $urandom_range(21, 1000);
      default: thr = $urandom_range(1001, 32767);
    endcase
    ei = ($urandom_range(0, 7) < 6) ? $urandom_range(0, 3) : $urandom_range(4, 12);
    program_regs(thr, ei, $urandom_range(0, 5), $urandom_range(0, 5));
  endtask

  initial begin : stimulus
    int k;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.left_sample <= '0;
    in_ch.right_sample <= '0;
    in_ch.period_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: eleven unjudged periods, then one judged right at the loud boundary.
    send_frame(16'sh7FFF, 16'sh8000, 1'b1);
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b1);
    send_frame(-16'sd1, -16'sd1, 1'b1);
    send_frame(16'sd1, 16'sd1, 1'b1);
    send_frame(16'sh5555, 16'shAAAA, 1'b1);
    send_frame(16'shAAAA, 16'sh5555, 1'b1);
    send_frame(16'sd100, 16'sd0, 1'b1);
    send_frame(16'sd0, -16'sd100, 1'b1);
    send_frame(16'sd12345, -16'sd12345, 1'b1);
    send_frame(-16'sd20000, 16'sd30000, 1'b1);
    send_frame(16'sd101, 16'sd0, 1'b1);
    finish_phase();

    // Every period judged: quiet just under the level, two loud to start sound, one quiet
    // to return to silence, then two-frame periods on either side of the boundary.
    program_regs(100, 0, 2, 1);
    send_frame(16'sd100, 16'sd0, 1'b1);
    send_frame(-16'sd101, 16'sd0, 1'b1);
    send_frame(16'sd0, 16'sd101, 1'b1);
    send_frame(16'sd71, 16'sd71, 1'b1);
    send_frame(16'sd101, 16'sd0, 1'b0);
    send_frame(16'sd0, -16'sd101, 1'b1);
    send_frame(-16'sd71, -16'sd71, 1'b0);
    send_frame(16'sd71, -16'sd71, 1'b1);
    finish_phase();

    program_regs(0, 0, 0, 0);
    run_mixed(60);
    finish_phase();

    program_regs(32767, 1, 1, 1);
    run_mixed(80);
    finish_phase();

    program_regs($urandom_range(1, 32767), 255, 255, 255);
    run_mixed(60);
    finish_phase();

    // A period with no end marker closes on its longest length; quiet periods follow so
    // that silence is declared again.
    program_regs($urandom_range(200, 5000), 0, 2, 3);
    send_period(PERIOD_FRAMES, pick_amp(cur_thr), 1'b0);
    for (k = 0; k < 5; k++) send_frame(16'sd0, 16'sd0, 1'b1);
    finish_phase();

    // Long loud run: the run counter saturates and sound begins only at the longest run.
    program_regs(1, 0, 255, 255);
    for (k = 0; k < 260; k++)
      send_frame(16'($urandom_range(0, 1) ? -$urandom_range(2, 32767) : $urandom_range(2, 32767)),
                 pick_sample(32768), 1'b1);
    for (k = 0; k < 20; k++)
      send_frame(16'(int'($urandom_range(0, 2)) - 1), 16'(int'($urandom_range(0, 2)) - 1), 1'b1);
    finish_phase();

    while (sent < ITEM_TARGET) begin
      random_config();
      run_mixed($urandom_range(40, 80));
      finish_phase();
    end

    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
design/assd_pkg.sv
design/assd_in_if.sv
design/assd_out_if.sv
design/assd_dp.sv
design/assd_ctrl.sv
design/audio_sound_silence_detector_top.sv
tb/assd_checker.sv
tb/tb.sv
